### design/cbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

  // Request codes
  localparam logic [2:0] REQ_TICK      = 3'd0;
  localparam logic [2:0] REQ_PRG_READ  = 3'd1;
  localparam logic [2:0] REQ_PRG_WRITE = 3'd2;
  localparam logic [2:0] REQ_CHR_READ  = 3'd3;
  localparam logic [2:0] REQ_CHR_WRITE = 3'd4;

  // Target memory codes
  localparam logic [2:0] TGT_NONE    = 3'd0;
  localparam logic [2:0] TGT_WRAM    = 3'd1;
  localparam logic [2:0] TGT_PRG_ROM = 3'd2;
  localparam logic [2:0] TGT_CHR_RAM = 3'd3;
  localparam logic [2:0] TGT_CHR_ROM = 3'd4;
  localparam logic [2:0] TGT_NT_RAM  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_HAS_PRG_RAM = 2'd0;
  localparam logic [1:0] CFG_HAS_CHR_RAM = 2'd1;
  localparam logic [1:0] CFG_HAS_EEPROM  = 2'd2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 1;

  typedef struct packed {
    logic has_prg_ram;
    logic has_chr_ram;
    logic has_eeprom;
  } cbm_cfg_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [18:0] mapped_address;
    logic [7:0]  read_data;
    logic        irq_line;
    logic        eeprom_scl;
    logic        eeprom_sda_out;
    logic        eeprom_strobe;
  } cbm_result_t;

endpackage

`default_nettype wire

### design/cbm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cbm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] bus_address;
  logic [7:0]  data_in;
  logic        eeprom_sda_in;

  modport source (
    output valid, req_type, bus_address, data_in, eeprom_sda_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, bus_address, data_in, eeprom_sda_in,
    output ready
  );
endinterface

`default_nettype wire

### design/cbm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [18:0] mapped_address;
  logic [7:0]  read_data;
  logic        irq_line;
  logic        eeprom_scl;
  logic        eeprom_sda_out;
  logic        eeprom_strobe;

  modport source (
    output valid, target, mapped_address, read_data, irq_line,
           eeprom_scl, eeprom_sda_out, eeprom_strobe,
    input  ready
  );

  modport sink (
    input  valid, target, mapped_address, read_data, irq_line,
           eeprom_scl, eeprom_sda_out, eeprom_strobe,
    output ready
  );
endinterface

`default_nettype wire

### design/cbm_core.sv
`timescale 1ns / 1ps
`default_nettype none

module cbm_core
  import cbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cbm_cfg_t    cfg,
  input  wire logic        fire,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] bus_address,
  input  wire logic [7:0]  data_in,
  input  wire logic        eeprom_sda_in,
  output cbm_result_t      res
);

  localparam logic [3:0] SEL_PRG_BANK   = 4'h8;
  localparam logic [3:0] SEL_MIRROR     = 4'h9;
  localparam logic [3:0] SEL_IRQ_CTRL   = 4'hA;
  localparam logic [3:0] SEL_RELOAD_LO  = 4'hB;
  localparam logic [3:0] SEL_RELOAD_HI  = 4'hC;
  localparam logic [3:0] SEL_EEPROM     = 4'hD;

  localparam logic [1:0] MIR_VERTICAL   = 2'd0;
  localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIR_SINGLE_LO  = 2'd2;

  logic [7:0]  chr_bank [8];
  logic [3:0]  prg_bank;
  logic [3:0]  prg_outer;
  logic [1:0]  mirror_mode;
  logic        ram_enabled;
  logic        irq_enabled;
  logic [15:0] irq_count;
  logic [15:0] irq_reload;
  logic        irq_asserted;
  logic [1:0]  eeprom_lines;

  logic [7:0]  chr_bank_next [8];
  logic [3:0]  prg_bank_next;
  logic [3:0]  prg_outer_next;
  logic [1:0]  mirror_mode_next;
  logic        ram_enabled_next;
  logic        irq_enabled_next;
  logic [15:0] irq_count_next;
  logic [15:0] irq_reload_next;
  logic        irq_asserted_next;
  logic [1:0]  eeprom_lines_next;

  logic        ram_on;
  logic        in_ram_win;
  logic        in_rom;
  logic [3:0]  sel;
  logic [3:0]  bank_lo;
  logic        bank_hi;
  logic [10:0] nt_addr;

  assign ram_on     = cfg.has_prg_ram & ram_enabled;
  assign in_ram_win = (bus_address[15:13] == 3'b011);
  assign in_rom     = bus_address[15];
  assign sel        = bus_address[3:0];
  assign bank_lo    = bus_address[14] ? 4'hF : prg_bank;
  assign bank_hi    = cfg.has_chr_ram & (|prg_outer);

  always_comb begin
    case (mirror_mode)
      MIR_VERTICAL:   nt_addr = {bus_address[10], bus_address[9:0]};
      MIR_HORIZONTAL: nt_addr = {bus_address[11], bus_address[9:0]};
      MIR_SINGLE_LO:  nt_addr = {1'b0, bus_address[9:0]};
      default:        nt_addr = {1'b1, bus_address[9:0]};
    endcase
  end

  always_comb begin
    chr_bank_next     = chr_bank;
    prg_bank_next     = prg_bank;
    prg_outer_next    = prg_outer;
    mirror_mode_next  = mirror_mode;
    ram_enabled_next  = ram_enabled;
    irq_enabled_next  = irq_enabled;
    irq_count_next    = irq_count;
    irq_reload_next   = irq_reload;
    irq_asserted_next = irq_asserted;
    eeprom_lines_next = eeprom_lines;
    res               = '0;

    case (req_type)
      REQ_TICK: begin
        if (irq_enabled) begin
          irq_count_next = irq_count - 16'd1;
          // wrap from zero raises the interrupt and stops the count
          if (irq_count == 16'h0000) begin
            irq_asserted_next = 1'b1;
            irq_enabled_next  = 1'b0;
          end
        end
      end
      REQ_PRG_READ: begin
        if (in_rom) begin
          res.target         = TGT_PRG_ROM;
          res.mapped_address = {bank_hi, bank_lo, bus_address[13:0]};
        end else if (in_ram_win && ram_on) begin
          res.target         = TGT_WRAM;
          res.mapped_address = {6'd0, bus_address[12:0]};
        end else begin
          res.read_data = data_in;
          if (in_ram_win && cfg.has_eeprom) begin
            res.read_data[4] = eeprom_sda_in;
          end
        end
      end
      REQ_PRG_WRITE: begin
        if (in_ram_win && ram_on) begin
          res.target         = TGT_WRAM;
          res.mapped_address = {6'd0, bus_address[12:0]};
        end else if (in_rom) begin
          if (sel == SEL_EEPROM) begin
            if (cfg.has_eeprom) begin
              eeprom_lines_next = {data_in[6], data_in[5]};
              res.eeprom_strobe = 1'b1;
            end
            ram_enabled_next = data_in[5];
          end else if (!sel[3]) begin
            chr_bank_next[sel[2:0]] = data_in;
            if (!sel[2]) begin
              prg_outer_next[sel[1:0]] = data_in[0];
            end
          end else begin
            case (sel)
              SEL_PRG_BANK: prg_bank_next    = data_in[3:0];
              SEL_MIRROR:   mirror_mode_next = data_in[1:0];
              SEL_IRQ_CTRL: begin
                irq_enabled_next  = data_in[0];
                irq_count_next    = irq_reload;
                irq_asserted_next = 1'b0;
              end
              SEL_RELOAD_LO: irq_reload_next = {irq_reload[15:8], data_in};
              SEL_RELOAD_HI: irq_reload_next = {data_in, irq_reload[7:0]};
              default: ;
            endcase
          end
        end
      end
      REQ_CHR_READ, REQ_CHR_WRITE: begin
        if (bus_address[13]) begin
          res.target         = TGT_NT_RAM;
          res.mapped_address = {8'd0, nt_addr};
        end else if (cfg.has_chr_ram) begin
          res.target         = TGT_CHR_RAM;
          res.mapped_address = {6'd0, bus_address[12:0]};
        end else if (req_type == REQ_CHR_READ) begin
          res.target         = TGT_CHR_ROM;
          res.mapped_address = {1'b0, chr_bank[bus_address[12:10]], bus_address[9:0]};
        end
      end
      default: ;
    endcase

    res.irq_line       = irq_asserted_next;
    res.eeprom_scl     = eeprom_lines_next[0];
    res.eeprom_sda_out = eeprom_lines_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        chr_bank[i] <= '0;
      end
      prg_bank     <= '0;
      prg_outer    <= '0;
      mirror_mode  <= '0;
      ram_enabled  <= 1'b0;
      irq_enabled  <= 1'b0;
      irq_count    <= '0;
      irq_reload   <= '0;
      irq_asserted <= 1'b0;
      eeprom_lines <= '0;
    end else if (fire) begin
      chr_bank     <= chr_bank_next;
      prg_bank     <= prg_bank_next;
      prg_outer    <= prg_outer_next;
      mirror_mode  <= mirror_mode_next;
      ram_enabled  <= ram_enabled_next;
      irq_enabled  <= irq_enabled_next;
      irq_count    <= irq_count_next;
      irq_reload   <= irq_reload_next;
      irq_asserted <= irq_asserted_next;
      eeprom_lines <= eeprom_lines_next;
    end
  end

endmodule

`default_nettype wire

### design/cartridge_bank_mapper_irq_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Cartridge mapper: bank switching, IRQ down-counter and EEPROM line port.
// req channel: one item per CPU tick or bus access (req_type, bus_address,
//   data_in, eeprom_sda_in). rsp channel: one item per request with the
//   target memory, translated address, read data and the IRQ and EEPROM
//   line levels after that request.
// Configuration: cfg_write with cfg_index/cfg_data sets has_prg_ram,
//   has_chr_ram and has_eeprom; write only while no item is in flight.
// Output: results are registered in the result register, or in the skid
//   buffer when it is full and not popped. Throughput: one item per cycle
//   while the skid buffer is empty; state updates and address translation
//   happen in the accept cycle, set by the register write plus decode path.
// Stall: a result register and a one-entry skid buffer hold results;
//   req.ready drops only while both are full.
// Reset (rst, synchronous): clears all mapper registers, the IRQ counter,
//   the EEPROM lines, the configuration and both output entries.

module cartridge_bank_mapper_irq_top
  import cbm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  cbm_req_if.sink                     req,
  cbm_rsp_if.source                   rsp
);

  cbm_cfg_t    cfg;
  cbm_result_t res;
  cbm_result_t out_data;
  cbm_result_t skid_data;
  logic        out_valid;
  logic        skid_valid;
  logic        fire;
  logic        pop;

  assign req.ready = !skid_valid;
  assign fire      = req.valid && !skid_valid;
  assign pop       = out_valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HAS_PRG_RAM: cfg.has_prg_ram <= cfg_data[0];
        CFG_HAS_CHR_RAM: cfg.has_chr_ram <= cfg_data[0];
        CFG_HAS_EEPROM:  cfg.has_eeprom  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cbm_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .fire          (fire),
    .req_type      (req.req_type),
    .bus_address   (req.bus_address),
    .data_in       (req.data_in),
    .eeprom_sda_in (req.eeprom_sda_in),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // drain the skid entry into the result register
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (fire) begin
      if (!out_valid || pop) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.target         = out_data.target;
  assign rsp.mapped_address = out_data.mapped_address;
  assign rsp.read_data      = out_data.read_data;
  assign rsp.irq_line       = out_data.irq_line;
  assign rsp.eeprom_scl     = out_data.eeprom_scl;
  assign rsp.eeprom_sda_out = out_data.eeprom_sda_out;
  assign rsp.eeprom_strobe  = out_data.eeprom_strobe;

endmodule

`default_nettype wire
